// ===== rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// shared types and constants of the bitmap first-fit block allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

	// default sizes of the managed area
	localparam int DEF_MAX_BLOCKS   = 1024;
	localparam int DEF_WORD_BITS    = 32;
	localparam int DEF_HEADER_BYTES = 16;

	// field widths
	localparam int CMD_W    = 1;
	localparam int REQ_W    = 16;
	localparam int START_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int STAT_W   = 2;
	localparam int UNIT_W   = 13;
	localparam int CFG_W    = 13;
	localparam int CFGIDX_W = 2;

	// internal widths: block positions up to a full 11 bit capacity plus a step
	localparam int BLK_W  = 12;
	localparam int DIVD_W = 17;
	localparam int NEED_W = 18;

	// blocks examined per scan cycle
	localparam int NIB = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// register indexes
	localparam logic [CFGIDX_W-1:0] REG_UNIT = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_CAP  = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_RESV = 2'd2;

	// register reset values
	localparam logic [UNIT_W-1:0]  RST_UNIT = 13'd16;
	localparam logic [COUNT_W-1:0] RST_CAP  = 11'd1024;
	localparam logic [COUNT_W-1:0] RST_RESV = 11'd4;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [REQ_W-1:0]   request_bytes;
		logic [START_W-1:0] free_start;
		logic [COUNT_W-1:0] free_count;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [START_W-1:0] start_block;
		logic [COUNT_W-1:0] block_count;
		logic [COUNT_W-1:0] used_blocks;
	} rsp_t;

endpackage

// ===== rtl/bitmap_first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit
// first-fit contiguous block allocator over an occupancy bitmap in memory
// ----------------------------------------------------------------------------
// usage
//  - cmd channel (cmd_valid / cmd_stall / cmd) takes one word per command:
//    allocate a byte count, or free a run of blocks
//  - rsp channel (rsp_valid / rsp_stall / rsp) returns one word per command:
//    status, start block, block count and the used count after the command
//  - cfg port writes unit size, capacity and reserved count; user must keep to idle, unchecked
//  - one command at a time; cmd_stall is high while a command is in work
//  - allocate: restoring division for the block count, then a scan of the
//    bitmap at four blocks a scan cycle, each map word read before its
//    blocks are scanned, then one read and one write per word of the run
//  - free: one read and one write per map word the run touches
//  - the single map memory port pair sets the pace of scan and update
//  - after reset the map memory is cleared one word a cycle with cmd_stall high
//  - the result sits in an output register; when the receiver stalls it
//    holds, and a new command may already be accepted and worked on
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_unit #(
	parameter int MAX_BLOCKS   = bffa_pkg::DEF_MAX_BLOCKS,
	parameter int WORD_BITS    = bffa_pkg::DEF_WORD_BITS,
	parameter int HEADER_BYTES = bffa_pkg::DEF_HEADER_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  bffa_pkg::cmd_t                cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bffa_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [bffa_pkg::CFGIDX_W-1:0] cfg_index,
	input  logic [bffa_pkg::CFG_W-1:0]    cfg_data
);
	import bffa_pkg::*;

	localparam int WSH       = $clog2(WORD_BITS);
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam logic [WSH-1:0] LAST_NIB = WSH'(WORD_BITS - NIB);
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);

	// sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_SRD  = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;
	localparam logic [2:0] ST_MRD  = 3'd6;
	localparam logic [2:0] ST_MWR  = 3'd7;
	localparam logic [2:0] ST_FIN  = 3'd7 ^ 3'd7;

	// ST_FIN needs its own code: use a fourth bit
	logic [3:0] state_q;
	localparam logic [3:0] S_CLR  = {1'b0, ST_CLR};
	localparam logic [3:0] S_IDLE = {1'b0, ST_IDLE};
	localparam logic [3:0] S_DIV  = {1'b0, ST_DIV};
	localparam logic [3:0] S_CHK  = {1'b0, ST_CHK};
	localparam logic [3:0] S_SRD  = {1'b0, ST_SRD};
	localparam logic [3:0] S_SCAN = {1'b0, ST_SCAN};
	localparam logic [3:0] S_MRD  = {1'b0, ST_MRD};
	localparam logic [3:0] S_MWR  = {1'b0, ST_MWR};
	localparam logic [3:0] S_FIN  = {1'b1, ST_FIN};

	// configuration registers
	logic [UNIT_W-1:0]  unit_q;
	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] resv_q;

	// map memory, one bit per block
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rd_en;
	logic [WA_W-1:0]      rd_addr;
	logic                 wr_en;
	logic [WA_W-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// command context
	logic                 free_q;
	logic [COUNT_W-1:0]   used_q;
	logic [STAT_W-1:0]    stat_q;
	logic [BLK_W-1:0]     lo_q;
	logic [BLK_W-1:0]     cnt_q;
	logic [BLK_W-1:0]     cleared_q;
	logic [WA_W-1:0]      w_q;
	logic [WA_W-1:0]      last_q;

	// divider
	logic [DIVD_W-1:0]    dvd_q;
	logic [UNIT_W:0]      rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [4:0]           dstep_q;
	logic [NEED_W-1:0]    need_q;

	// scan
	logic [BLK_W-1:0]     b_q;
	logic [BLK_W-1:0]     run_q;

	// output register
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 fin_fire;

	// effective capacity
	logic [31:0]      cap32;
	logic [BLK_W-1:0] cap_eff;
	assign cap32   = (32'(cap_q) < 32'(MAX_BLOCKS)) ? 32'(cap_q) : 32'(MAX_BLOCKS);
	assign cap_eff = BLK_W'(cap32);

	// divider step
	logic [UNIT_W-1:0] unit_eff;
	logic [UNIT_W:0]   rem_sh;
	logic              qbit;
	logic [UNIT_W:0]   rem_nx;
	assign unit_eff = (unit_q == '0) ? UNIT_W'(1) : unit_q;
	assign rem_sh   = {rem_q[UNIT_W-1:0], dvd_q[DIVD_W-1]};
	assign qbit     = rem_sh >= {1'b0, unit_eff};
	assign rem_nx   = qbit ? (rem_sh - {1'b0, unit_eff}) : rem_sh;

	// scan of four blocks a cycle
	logic [BLK_W-1:0] run_v;
	logic             found_v;
	logic [BLK_W-1:0] fstart_v;
	logic [BLK_W-1:0] bb;
	logic [WSH-1:0]   bit_i;
	logic             occ;
	logic [BLK_W:0]   b_next;
	always_comb begin
		run_v    = run_q;
		found_v  = 1'b0;
		fstart_v = '0;
		bb       = '0;
		bit_i    = '0;
		occ      = 1'b0;
		for (int i = 0; i < NIB; i++) begin
			bb    = b_q + BLK_W'(i);
			bit_i = b_q[WSH-1:0] + WSH'(i);
			occ   = (bb < {1'b0, resv_q}) || rdata_q[bit_i];
			if (!found_v && (bb < cap_eff)) begin
				run_v = occ ? '0 : run_v + BLK_W'(1);
				if ({{(NEED_W-BLK_W){1'b0}}, run_v} == need_q) begin
					found_v  = 1'b1;
					fstart_v = bb + BLK_W'(1) - BLK_W'(need_q);
				end
			end
		end
	end
	assign b_next = {1'b0, b_q} + (BLK_W+1)'(NIB);

	// run mask over one word and the bits it clears
	logic [WORD_BITS-1:0] mask;
	logic [BLK_W-1:0]     hi;
	logic [31:0]          pos;
	logic [WORD_BITS-1:0] hit;
	always_comb begin
		hi  = lo_q + cnt_q;
		pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pos     = (32'(w_q) << WSH) | 32'(j);
			mask[j] = (pos >= 32'(lo_q)) && (pos < 32'(hi));
		end
	end
	assign hit = rdata_q & mask;

	// used count at the end of the command
	logic [COUNT_W:0]   used_sum;
	logic [COUNT_W-1:0] used_fin;
	always_comb begin
		used_sum = {1'b0, used_q} + (COUNT_W+1)'(cnt_q);
		used_fin = used_q;
		if (stat_q == STAT_OK) begin
			if (free_q) begin
				used_fin = ({1'b0, used_q} > cleared_q) ?
					COUNT_W'({1'b0, used_q} - cleared_q) : '0;
			end else begin
				used_fin = used_sum[COUNT_W] ? COUNT_MAX : used_sum[COUNT_W-1:0];
			end
		end
	end

	// memory port control
	always_comb begin
		rd_en   = (state_q == S_SRD) || (state_q == S_MRD);
		rd_addr = (state_q == S_SRD) ? WA_W'(b_q >> WSH) : w_q;
		wr_en   = (state_q == S_CLR) || (state_q == S_MWR);
		wr_addr = w_q;
		wr_data = '0;
		if (state_q == S_MWR) begin
			wr_data = free_q ? (rdata_q & ~mask) : (rdata_q | mask);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= RST_UNIT;
			cap_q  <= RST_CAP;
			resv_q <= RST_RESV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNIT: unit_q <= cfg_data[UNIT_W-1:0];
				REG_CAP:  cap_q  <= cfg_data[COUNT_W-1:0];
				REG_RESV: resv_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	logic [BLK_W:0] fsum;
	assign fsum = {2'b0, cmd.free_start} + {1'b0, cmd.free_count};

	// finish step hands over unless an older result is still held
	assign fin_fire = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			w_q         <= '0;
			used_q      <= RST_RESV;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			free_q      <= 1'b0;
			stat_q      <= STAT_OK;
			lo_q        <= '0;
			cnt_q       <= '0;
			cleared_q   <= '0;
			last_q      <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			dstep_q     <= '0;
			need_q      <= '0;
			b_q         <= '0;
			run_q       <= '0;
		end else begin
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					// zero one map word a cycle
					if (w_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
					w_q <= w_q + WA_W'(1);
				end
				S_IDLE: begin
					if (cmd_valid) begin
						free_q    <= (cmd.command == CMD_FREE);
						cleared_q <= '0;
						stat_q    <= STAT_OK;
						lo_q      <= BLK_W'(cmd.free_start);
						cnt_q     <= BLK_W'(cmd.free_count);
						dvd_q     <= DIVD_W'(cmd.request_bytes) + DIVD_W'(HEADER_BYTES);
						rem_q     <= '0;
						quo_q     <= '0;
						dstep_q   <= '0;
						if (cmd.command == CMD_ALLOC) begin
							state_q <= S_DIV;
						end else if (fsum > {1'b0, cap_eff}) begin
							stat_q  <= STAT_RANGE;
							state_q <= S_FIN;
						end else if (cmd.free_count == '0) begin
							state_q <= S_FIN;
						end else begin
							w_q     <= WA_W'(cmd.free_start >> WSH);
							last_q  <= WA_W'((fsum[BLK_W-1:0] - BLK_W'(1)) >> WSH);
							state_q <= S_MRD;
						end
					end
				end
				S_DIV: begin
					rem_q   <= rem_nx;
					quo_q   <= {quo_q[DIVD_W-2:0], qbit};
					dvd_q   <= dvd_q << 1;
					dstep_q <= dstep_q + 5'd1;
					if (dstep_q == 5'(DIVD_W - 1)) begin
						need_q  <= {1'b0, quo_q[DIVD_W-2:0], qbit} + NEED_W'(1);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					b_q   <= '0;
					run_q <= '0;
					if (need_q > NEED_W'(cap_eff)) begin
						stat_q  <= STAT_NOMEM;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					run_q <= run_v;
					if (found_v) begin
						lo_q    <= fstart_v;
						cnt_q   <= BLK_W'(need_q);
						w_q     <= WA_W'(fstart_v >> WSH);
						last_q  <= WA_W'((fstart_v + BLK_W'(need_q) - BLK_W'(1)) >> WSH);
						state_q <= S_MRD;
					end else if (b_next >= {1'b0, cap_eff}) begin
						stat_q  <= STAT_NOMEM;
						state_q <= S_FIN;
					end else begin
						b_q <= b_next[BLK_W-1:0];
						if (b_q[WSH-1:0] == LAST_NIB) begin
							state_q <= S_SRD;
						end
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					cleared_q <= cleared_q + BLK_W'($countones(hit));
					if (w_q == last_q) begin
						state_q <= S_FIN;
					end else begin
						w_q     <= w_q + WA_W'(1);
						state_q <= S_MRD;
					end
				end
				S_FIN: begin
					// wait here only while an older result is still held
					if (fin_fire) begin
						rsp_q.status      <= stat_q;
						rsp_q.start_block <= (stat_q == STAT_OK) ? START_W'(lo_q) : '0;
						rsp_q.block_count <= (stat_q == STAT_OK) ? COUNT_W'(cnt_q) : '0;
						rsp_q.used_blocks <= used_fin;
						used_q            <= used_fin;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a new result only comes out of the finish step
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish step");

	// no command is taken while the map is being cleared
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> cmd_stall)
		else $error("command accepted during map clear");

	// failed allocate reports an empty run
	a_nomem_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STAT_NOMEM) |->
		(rsp.start_block == '0 && rsp.block_count == '0))
		else $error("failed allocate reports a run");

	// the run update never walks past its last word
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MWR) |-> (w_q <= last_q))
		else $error("map update past end of run");

	// a held result keeps its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> $stable(rsp))
		else $error("held result changed");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit block allocator: a local model of the
// occupancy map and used count predicts each response word, which is compared
// field by field; directed corner cases, register sweeps, backpressure, random traffic
// ----------------------------------------------------------------------------
module tb_top;
	import bffa_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int TAIL_CYCLES  = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFGIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// model state
	bit [1023:0] occ_map;
	int unsigned used_cnt;
	int unsigned unit_reg, cap_reg, resv_reg;
	rsp_t pending_rsp[$];

	int errors = 0;
	int n_cmds = 0;
	int n_rsps = 0;
	int n_alloc_ok = 0;
	int n_nomem = 0;
	int n_range = 0;
	int cycles = 0;
	// random stall shaping
	bit stall_hold = 1'b0;
	int hold_len = 0;
	bit rsp_jitter = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	bitmap_first_fit_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// predicts the response word of one command and updates the map
	function automatic rsp_t allocate_or_free(cmd_t c);
		rsp_t r;
		int unsigned cap, unit, need, run, b, st, cleared;
		bit found;
		r = '0;
		cap = (cap_reg < 1024) ? cap_reg : 1024;
		found = 1'b0;
		st = 0;
		if (c.command == CMD_ALLOC) begin
			unit = (unit_reg == 0) ? 1 : unit_reg;
			need = (c.request_bytes + 16) / unit + 1;
			run = 0;
			if (need <= cap) begin
				for (b = 0; b < cap; b++) begin
					if (b < resv_reg || occ_map[b]) run = 0;
					else run++;
					if (run == need) begin
						st = b + 1 - need;
						found = 1'b1;
						break;
					end
				end
			end
			if (found) begin
				for (b = st; b < st + need; b++) occ_map[b] = 1'b1;
				used_cnt += need;
				if (used_cnt > 2047) used_cnt = 2047;
				r.status = STAT_OK;
				r.start_block = st[START_W-1:0];
				r.block_count = need[COUNT_W-1:0];
			end else begin
				r.status = STAT_NOMEM;
			end
		end else begin
			if (c.free_start + c.free_count > cap) begin
				r.status = STAT_RANGE;
			end else begin
				cleared = 0;
				for (b = c.free_start; b < c.free_start + c.free_count; b++) begin
					if (b < 1024 && occ_map[b]) begin
						cleared++;
						occ_map[b] = 1'b0;
					end
				end
				used_cnt = (used_cnt > cleared) ? used_cnt - cleared : 0;
				r.status = STAT_OK;
				r.start_block = c.free_start;
				r.block_count = c.free_count;
			end
		end
		r.used_blocks = used_cnt[COUNT_W-1:0];
		return r;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout with %0d responses outstanding", pending_rsp.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stall: random gaps, or one long hold-off when requested
	always @(posedge clk) begin
		if (stall_hold) begin
			rsp_stall <= 1'b1;
		end else if (hold_len > 0) begin
			hold_len <= hold_len - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_jitter && $urandom_range(0, 99) < 30) begin
			hold_len <= rand_gap();
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rsps++;
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected: %h", rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.start_block !== e.start_block) begin
					$error("start_block expected %0d actual %0d", e.start_block,
						rsp.start_block);
					errors++;
				end
				if (rsp.block_count !== e.block_count) begin
					$error("block_count expected %0d actual %0d", e.block_count,
						rsp.block_count);
					errors++;
				end
				if (rsp.used_blocks !== e.used_blocks) begin
					$error("used_blocks expected %0d actual %0d", e.used_blocks,
						rsp.used_blocks);
					errors++;
				end
				if (e.status == STAT_NOMEM) n_nomem++;
				else if (e.status == STAT_RANGE) n_range++;
			end
		end
	end

	// send one command word; prediction happens at the accepting edge
	// valid stays up after the accept until the next word or an idle point
	task automatic send_cmd(cmd_t c, bit gaps = 1'b1);
		int unsigned g;
		rsp_t e;
		g = gaps ? rand_gap() : 0;
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		e = allocate_or_free(c);
		pending_rsp.push_back(e);
		if (c.command == CMD_ALLOC && e.status == STAT_OK) n_alloc_ok++;
		n_cmds++;
	endtask

	task automatic alloc_cmd(int unsigned bytes, bit gaps = 1'b1);
		cmd_t c;
		c = '0;
		c.command = CMD_ALLOC;
		c.request_bytes = bytes[REQ_W-1:0];
		c.free_start = START_W'($urandom());
		c.free_count = COUNT_W'($urandom());
		send_cmd(c, gaps);
	endtask

	task automatic free_cmd(int unsigned st, int unsigned cnt, bit gaps = 1'b1);
		cmd_t c;
		c = '0;
		c.command = CMD_FREE;
		c.request_bytes = REQ_W'($urandom());
		c.free_start = st[START_W-1:0];
		c.free_count = cnt[COUNT_W-1:0];
		send_cmd(c, gaps);
	endtask

	// wait for all responses plus the latency of a trailing scan
	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFGIDX_W-1:0] idx, int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_UNIT: unit_reg = val & 13'h1fff;
			REG_CAP:  cap_reg = val & 11'h7ff;
			REG_RESV: resv_reg = val & 11'h7ff;
			default: ;
		endcase
	endtask

	// empty the map so later phases start clean
	task automatic free_all();
		int unsigned cap;
		cap = (cap_reg < 1024) ? cap_reg : 1024;
		free_cmd(0, cap);
	endtask

	task automatic test_directed();
		alloc_cmd(0, 0);              // smallest request
		alloc_cmd(16'hffff, 0);       // largest request, 4097 blocks: no memory
		alloc_cmd(1007, 0);           // mid-size request, 64 blocks
		alloc_cmd(1, 0);              // small request, 2 blocks
		free_cmd(0, 8, 0);            // run covers reserved and allocated blocks
		free_cmd(0, 8, 0);            // double free
		free_cmd(1023, 1, 0);         // last block
		free_cmd(1023, 2, 0);         // run past capacity
		free_cmd(10'h3ff, 11'h7ff, 0); // all field bits set
		free_cmd(5, 0, 0);            // empty run
		free_cmd(0, 1024, 0);
		alloc_cmd(100, 0);
		alloc_cmd(200, 0);
		free_cmd(4, 8, 0);            // hole at the front
		alloc_cmd(20, 0);             // fits in the hole
		alloc_cmd(200, 0);            // skips the hole
		free_all();
	endtask

	task automatic test_registers();
		write_reg(REG_UNIT, 0);       // zero unit acts as one
		alloc_cmd(5, 0);
		alloc_cmd(1100, 0);
		write_reg(REG_UNIT, 8191);
		alloc_cmd(16'hffff, 0);
		write_reg(REG_UNIT, 4096);
		alloc_cmd(16'hffff, 0);
		write_reg(REG_CAP, 0);        // nothing fits, only empty frees
		alloc_cmd(0, 0);
		free_cmd(0, 0, 0);
		free_cmd(0, 1, 0);
		write_reg(REG_CAP, 2047);     // above the array size
		free_cmd(1000, 24, 0);
		free_cmd(1000, 25, 0);
		write_reg(REG_RESV, 2047);    // everything reserved
		alloc_cmd(0, 0);
		write_reg(REG_RESV, 0);
		free_all();
		write_reg(REG_UNIT, 1);
		alloc_cmd(1006, 0);
		alloc_cmd(0, 0);
		free_all();
		write_reg(REG_CAP, 1);
		alloc_cmd(0, 0);
		write_reg(REG_UNIT, 17);
		alloc_cmd(0, 0);
		free_cmd(0, 1, 0);
		write_reg(REG_CAP, 1024);
		write_reg(REG_UNIT, 16);
		write_reg(REG_RESV, 4);
		free_all();
	endtask

	// the receiver holds off while commands keep coming
	task automatic test_backpressure();
		int k;
		stall_hold = 1'b1;
		fork
			begin
				for (k = 0; k < 6; k++) alloc_cmd($urandom_range(0, 200), 0);
				cmd_valid <= 1'b0;
			end
			begin
				repeat (3000) @(posedge clk);
				stall_hold = 1'b0;
			end
		join
		drain();
		free_all();
	endtask

	task automatic random_phase(int n, int unsigned max_req);
		int i;
		int unsigned r, st, cnt, cap;
		cap = (cap_reg < 1024) ? cap_reg : 1024;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				alloc_cmd($urandom_range(0, max_req));
			end else if (r < 60) begin
				alloc_cmd($urandom());
			end else if (r < 90 && cap > 0) begin
				st = $urandom_range(0, cap - 1);
				cnt = $urandom_range(0, (cap - st < 64) ? cap - st : 64);
				free_cmd(st, cnt);
			end else begin
				free_cmd($urandom(), $urandom());
			end
			// sender pauses until everything is back
			if (i % 200 == 199) begin
				cmd_valid <= 1'b0;
				while (pending_rsp.size() != 0) @(posedge clk);
			end
		end
	endtask

	task automatic test_random();
		random_phase(600, 600);
		write_reg(REG_UNIT, $urandom_range(1, 64));
		write_reg(REG_RESV, $urandom_range(0, 40));
		free_all();
		random_phase(500, 2000);
		write_reg(REG_CAP, $urandom_range(40, 300));
		write_reg(REG_UNIT, 4);
		free_all();
		rsp_jitter = 1'b0;
		random_phase(200, 100);
		rsp_jitter = 1'b1;
		write_reg(REG_CAP, 1024);
		write_reg(REG_UNIT, 16);
		write_reg(REG_RESV, 4);
		random_phase(600, 400);
	endtask

	initial begin
		occ_map = '0;
		unit_reg = RST_UNIT;
		cap_reg = RST_CAP;
		resv_reg = RST_RESV;
		used_cnt = RST_RESV;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_backpressure();
		test_random();
		drain();
		$display("%0d commands, %0d responses: %0d good allocations, %0d out of memory,",
			n_cmds, n_rsps, n_alloc_ok, n_nomem);
		$display("%0d bad free ranges, over several unit, capacity and reserve settings",
			n_range);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== bitmap_first_fit_block_allocator_unit.f =====
rtl/bffa_pkg.sv
rtl/bitmap_first_fit_block_allocator_unit.sv
verif/tb_top.sv
